// ===== hdl/hfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hfsd_pkg
// Shared types and constants for the hex floating text to binary64 converter.
// ----------------------------------------------------------------------------
package hfsd_pkg;

  // Kept significand and exponent magnitude widths
  localparam int MANT_W      = 64;
  localparam int EXP_MAG_W   = 24;
  localparam int LEAD_W      = 3;
  localparam int QUEUE_DEPTH = 4;

  // Saturation point of the decimal exponent magnitude
  localparam logic [EXP_MAG_W-1:0] EXP_LIMIT = 24'd16777215;

  // Parser phases
  typedef enum logic [3:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_MANT,
    PH_EXP,
    PH_EXP_PLUS,
    PH_EXP_MINUS,
    PH_EXP_DIG_PLUS,
    PH_EXP_DIG_MINUS,
    PH_TRAIL,
    PH_OTHER,
    PH_DONE
  } phase_t;

  // Status of one finished text, front to back
  typedef struct packed {
    logic hex_form;
    logic negative;
    logic nonzero;
    logic sticky;
    logic exp_neg;
  } fin_flags_t;

endpackage

// ===== hdl/hfsd_front.sv =====
// ----------------------------------------------------------------------------
// hfsd_front
// Byte parser: one text byte per cycle while the queue has room, emits a finished record at text end.
// ----------------------------------------------------------------------------
module hfsd_front #(
  parameter int MAX_LEN = 4096,
  parameter int KEPT    = 16,
  parameter int LEN_W   = 13,
  parameter int KC_W    = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_text_byte,
  input  logic                         in_starts_text,
  output logic                         fin_push,
  input  logic                         fin_room,
  output hfsd_pkg::fin_flags_t         fin_flags,
  output logic [hfsd_pkg::MANT_W-1:0]  fin_mant,
  output logic [hfsd_pkg::LEAD_W-1:0]  fin_lead,
  output logic [KC_W-1:0]              fin_kept,
  output logic [LEN_W-1:0]             fin_radix,
  output logic [LEN_W-1:0]             fin_fnz,
  output logic [LEN_W-1:0]             fin_acc,
  output logic [hfsd_pkg::EXP_MAG_W-1:0] fin_exp_mag
);
  import hfsd_pkg::*;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CASE_BIT = 8'h20;

  phase_t                 phase_r, phase_nxt, cur_phase;
  logic                   neg_r, neg_nxt, cur_neg;
  logic [MANT_W-1:0]      mant_r, mant_nxt, cur_mant;
  logic [KC_W-1:0]        kept_r, kept_nxt, cur_kept;
  logic [LEN_W-1:0]       digits_r, digits_nxt, cur_digits;
  logic [LEN_W-1:0]       point_r, point_nxt, cur_point;
  logic [LEN_W-1:0]       fnz_r, fnz_nxt, cur_fnz;
  logic                   dig_r, dig_nxt, cur_dig;
  logic                   pt_r, pt_nxt, cur_pt;
  logic                   nz_r, nz_nxt, cur_nz;
  logic                   sticky_r, sticky_nxt, cur_sticky;
  logic [LEAD_W-1:0]      lead_r, lead_nxt, cur_lead;
  logic [EXP_MAG_W-1:0]   emag_r, emag_nxt, cur_emag;
  logic                   eneg_r, eneg_nxt, cur_eneg;
  logic [LEN_W-1:0]       pos_r, pos_nxt, cur_pos;
  logic [LEN_W-1:0]       acc_r, acc_nxt, cur_acc;

  logic                   accept;
  logic                   end_byte;
  logic [7:0]             lower_c;
  logic                   is_hex;
  logic                   is_dec;
  logic [3:0]             hex_val;
  logic [3:0]             dec_val;
  logic                   exp_minus;
  logic [EXP_MAG_W+3:0]   emag_mul;

  // Bit length of a nonzero hex digit
  function automatic logic [LEAD_W-1:0] digit_len(input logic [3:0] v);
    logic [LEAD_W-1:0] n;
    if (v[3]) n = 3'd4;
    else if (v[2]) n = 3'd3;
    else if (v[1]) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  assign in_ready = fin_room;
  assign accept   = in_valid && in_ready;

  // A start byte sees the cleared parse state
  assign cur_phase  = in_starts_text ? PH_LEAD : phase_r;
  assign cur_neg    = in_starts_text ? 1'b0 : neg_r;
  assign cur_mant   = in_starts_text ? '0 : mant_r;
  assign cur_kept   = in_starts_text ? '0 : kept_r;
  assign cur_digits = in_starts_text ? '0 : digits_r;
  assign cur_point  = in_starts_text ? '0 : point_r;
  assign cur_fnz    = in_starts_text ? '0 : fnz_r;
  assign cur_dig    = in_starts_text ? 1'b0 : dig_r;
  assign cur_pt     = in_starts_text ? 1'b0 : pt_r;
  assign cur_nz     = in_starts_text ? 1'b0 : nz_r;
  assign cur_sticky = in_starts_text ? 1'b0 : sticky_r;
  assign cur_lead   = in_starts_text ? '0 : lead_r;
  assign cur_emag   = in_starts_text ? '0 : emag_r;
  assign cur_eneg   = in_starts_text ? 1'b0 : eneg_r;
  assign cur_pos    = in_starts_text ? '0 : pos_r;
  assign cur_acc    = in_starts_text ? '0 : acc_r;

  // Character classes
  assign lower_c  = in_text_byte | CASE_BIT;
  assign is_dec   = (in_text_byte >= CH_0) && (in_text_byte <= CH_9);
  assign dec_val  = 4'(in_text_byte - CH_0);
  assign is_hex   = is_dec || ((lower_c >= CH_LA) && (lower_c <= CH_LF));
  assign hex_val  = is_dec ? dec_val : 4'(lower_c - CH_LA + 8'd10);
  assign end_byte = (in_text_byte == CH_NUL) || (cur_pos >= LEN_W'(MAX_LEN));

  // Exponent accumulation with saturation
  assign exp_minus = (cur_phase == PH_EXP_MINUS) || (cur_phase == PH_EXP_DIG_MINUS);
  assign emag_mul  = ((EXP_MAG_W+4)'(cur_emag) << 3) + ((EXP_MAG_W+4)'(cur_emag) << 1)
                   + (EXP_MAG_W+4)'(dec_val);

  // Finished record taken from the current parse state
  assign fin_flags.hex_form = !(cur_phase inside {PH_LEAD, PH_SIGNED, PH_ZERO, PH_OTHER});
  assign fin_flags.negative = cur_neg;
  assign fin_flags.nonzero  = cur_nz;
  assign fin_flags.sticky   = cur_sticky;
  assign fin_flags.exp_neg  = cur_eneg;
  assign fin_mant    = cur_mant;
  assign fin_lead    = cur_lead;
  assign fin_kept    = cur_kept;
  assign fin_radix   = cur_pt ? cur_point : cur_digits;
  assign fin_fnz     = cur_fnz;
  assign fin_acc     = cur_acc;
  assign fin_exp_mag = cur_emag;

  // Next state and parse updates
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    mant_nxt   = mant_r;
    kept_nxt   = kept_r;
    digits_nxt = digits_r;
    point_nxt  = point_r;
    fnz_nxt    = fnz_r;
    dig_nxt    = dig_r;
    pt_nxt     = pt_r;
    nz_nxt     = nz_r;
    sticky_nxt = sticky_r;
    lead_nxt   = lead_r;
    emag_nxt   = emag_r;
    eneg_nxt   = eneg_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    fin_push   = 1'b0;
    if (accept) begin
      phase_nxt  = cur_phase;
      neg_nxt    = cur_neg;
      mant_nxt   = cur_mant;
      kept_nxt   = cur_kept;
      digits_nxt = cur_digits;
      point_nxt  = cur_point;
      fnz_nxt    = cur_fnz;
      dig_nxt    = cur_dig;
      pt_nxt     = cur_pt;
      nz_nxt     = cur_nz;
      sticky_nxt = cur_sticky;
      lead_nxt   = cur_lead;
      emag_nxt   = cur_emag;
      eneg_nxt   = cur_eneg;
      pos_nxt    = cur_pos;
      acc_nxt    = cur_acc;
      if (cur_phase != PH_DONE) begin
        if (end_byte) begin
          fin_push  = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          pos_nxt = cur_pos + 1'b1;
          case (cur_phase)
            PH_LEAD, PH_SIGNED: begin
              if ((cur_phase == PH_LEAD) &&
                  ((in_text_byte == CH_SPACE) ||
                   ((in_text_byte >= CH_TAB) && (in_text_byte <= CH_CR)))) begin
                phase_nxt = PH_LEAD;
              end else if ((cur_phase == PH_LEAD) &&
                           ((in_text_byte == CH_PLUS) || (in_text_byte == CH_MINUS))) begin
                neg_nxt   = (in_text_byte == CH_MINUS);
                phase_nxt = PH_SIGNED;
              end else if (in_text_byte == CH_0) begin
                acc_nxt   = cur_pos + 1'b1;
                phase_nxt = PH_ZERO;
              end else begin
                phase_nxt = PH_OTHER;
              end
            end
            PH_ZERO: begin
              phase_nxt = (lower_c == CH_LX) ? PH_MANT : PH_OTHER;
            end
            PH_MANT: begin
              if (is_hex) begin
                dig_nxt = 1'b1;
                if (!cur_nz && (hex_val != 4'd0)) begin
                  nz_nxt   = 1'b1;
                  fnz_nxt  = cur_digits;
                  lead_nxt = digit_len(hex_val);
                end
                if (cur_nz || (hex_val != 4'd0)) begin
                  if (cur_kept < KC_W'(KEPT)) begin
                    mant_nxt = {cur_mant[MANT_W-5:0], hex_val};
                    kept_nxt = cur_kept + 1'b1;
                  end else if (hex_val != 4'd0) begin
                    sticky_nxt = 1'b1;
                  end
                end
                if (cur_digits < LEN_W'(MAX_LEN)) digits_nxt = cur_digits + 1'b1;
                acc_nxt = cur_pos + 1'b1;
              end else if ((in_text_byte == CH_POINT) && !cur_pt) begin
                pt_nxt    = 1'b1;
                point_nxt = cur_digits;
                if (cur_dig) acc_nxt = cur_pos + 1'b1;
              end else if ((lower_c == CH_LP) && cur_dig) begin
                phase_nxt = PH_EXP;
              end else begin
                phase_nxt = PH_TRAIL;
              end
            end
            PH_EXP, PH_EXP_PLUS, PH_EXP_MINUS, PH_EXP_DIG_PLUS, PH_EXP_DIG_MINUS: begin
              if ((cur_phase == PH_EXP) && (in_text_byte == CH_PLUS)) begin
                phase_nxt = PH_EXP_PLUS;
              end else if ((cur_phase == PH_EXP) && (in_text_byte == CH_MINUS)) begin
                phase_nxt = PH_EXP_MINUS;
              end else if (is_dec) begin
                if (emag_mul > (EXP_MAG_W+4)'(EXP_LIMIT)) emag_nxt = EXP_LIMIT;
                else emag_nxt = emag_mul[EXP_MAG_W-1:0];
                eneg_nxt  = exp_minus;
                acc_nxt   = cur_pos + 1'b1;
                phase_nxt = exp_minus ? PH_EXP_DIG_MINUS : PH_EXP_DIG_PLUS;
              end else begin
                phase_nxt = PH_TRAIL;
              end
            end
            default: begin
              phase_nxt = cur_phase;
            end
          endcase
        end
      end
    end
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r    <= 1'b0;
      mant_r   <= '0;
      kept_r   <= '0;
      digits_r <= '0;
      point_r  <= '0;
      fnz_r    <= '0;
      dig_r    <= 1'b0;
      pt_r     <= 1'b0;
      nz_r     <= 1'b0;
      sticky_r <= 1'b0;
      lead_r   <= '0;
      emag_r   <= '0;
      eneg_r   <= 1'b0;
      pos_r    <= '0;
      acc_r    <= '0;
    end else begin
      neg_r    <= neg_nxt;
      mant_r   <= mant_nxt;
      kept_r   <= kept_nxt;
      digits_r <= digits_nxt;
      point_r  <= point_nxt;
      fnz_r    <= fnz_nxt;
      dig_r    <= dig_nxt;
      pt_r     <= pt_nxt;
      nz_r     <= nz_nxt;
      sticky_r <= sticky_nxt;
      lead_r   <= lead_nxt;
      emag_r   <= emag_nxt;
      eneg_r   <= eneg_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

// ===== hdl/hfsd_queue.sv =====
// ----------------------------------------------------------------------------
// hfsd_queue
// Short register queue of finished records between parser and rounder.
// ----------------------------------------------------------------------------
module hfsd_queue #(
  parameter int WIDTH = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  import hfsd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming record
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== hdl/hfsd_back.sv =====
// ----------------------------------------------------------------------------
// hfsd_back
// Three-stage rounder: align, shift and pick round bits, round and pack.
// ----------------------------------------------------------------------------
module hfsd_back #(
  parameter int LEN_W = 13,
  parameter int KC_W  = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hfsd_pkg::fin_flags_t           in_flags,
  input  logic [hfsd_pkg::MANT_W-1:0]    in_mant,
  input  logic [hfsd_pkg::LEAD_W-1:0]    in_lead,
  input  logic [KC_W-1:0]                in_kept,
  input  logic [LEN_W-1:0]               in_radix,
  input  logic [LEN_W-1:0]               in_fnz,
  input  logic [LEN_W-1:0]               in_acc,
  input  logic [hfsd_pkg::EXP_MAG_W-1:0] in_exp_mag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [63:0]                    out_value_bits,
  output logic [LEN_W-1:0]               out_consumed_length,
  output logic                           out_range_error,
  output logic                           out_hex_form
);
  import hfsd_pkg::*;

  localparam int E_W   = (((LEN_W + 3) > (EXP_MAG_W + 2)) ? (LEN_W + 3) : (EXP_MAG_W + 2)) + 2;
  localparam int SIG_W = 53;
  localparam int FRC_W = 52;
  localparam int EXP_W = 11;

  localparam logic signed [E_W-1:0] TOP_MAX      = E_W'(1023);
  localparam logic signed [E_W-1:0] TOP_MIN      = E_W'(-1075);
  localparam logic signed [E_W-1:0] TOP_NORM_MIN = E_W'(-1022);
  localparam logic        [E_W-1:0] SUB_BASE     = E_W'(-1011);
  localparam logic        [E_W-1:0] FIELD_BIAS   = E_W'(1022);
  localparam logic        [6:0]     NORM_SHIFT   = 7'd11;
  localparam logic [EXP_W-1:0]      EXP_ALL      = 11'h7ff;

  // Stage A: exponent of the leading bit and left-aligned significand
  logic                  va_r;
  fin_flags_t            fa_r;
  logic [LEN_W-1:0]      acca_r;
  logic signed [E_W-1:0] topa_r;
  logic [MANT_W-1:0]     norma_r;
  logic [E_W-1:0]        exp_ext;
  logic [E_W-1:0]        exp_s;
  logic [E_W-1:0]        topa_nxt;
  logic [7:0]            lsh;
  logic                  a_ready;

  // Stage B: classified, shifted significand and round bits
  logic                  vb_r;
  fin_flags_t            fb_r;
  logic [LEN_W-1:0]      accb_r;
  logic                  overb_r;
  logic                  underb_r;
  logic                  normb_r;
  logic [EXP_W-1:0]      fieldb_r;
  logic [SIG_W-1:0]      sigb_r;
  logic                  guardb_r;
  logic                  lowerb_r;
  logic                  over_nxt;
  logic                  under_nxt;
  logic                  norm_nxt;
  logic [E_W-1:0]        sub_amt;
  logic [6:0]            rsh;
  logic [MANT_W-1:0]     shifted;
  logic [5:0]            gidx;
  logic                  b_ready;

  // Stage C: packed result
  logic                  vc_r;
  logic [63:0]           value_r, value_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  rng_r, rng_nxt;
  logic                  hex_r;
  logic                  inc;
  logic [62:0]           mag;
  logic                  c_ready;

  // Stall chain from the output register back to the queue
  assign c_ready  = !vc_r || out_ready;
  assign b_ready  = !vb_r || c_ready;
  assign a_ready  = !va_r || b_ready;
  assign in_ready = a_ready;

  // top = exponent + 4 * (radix - first nonzero) + leading digit length - 5
  assign exp_ext  = E_W'(in_exp_mag);
  assign exp_s    = in_flags.exp_neg ? (~exp_ext + 1'b1) : exp_ext;
  assign topa_nxt = exp_s + ((E_W'(in_radix) - E_W'(in_fnz)) << 2) + E_W'(in_lead) - E_W'(5);
  assign lsh      = 8'd68 - 8'({in_kept, 2'b00}) - 8'(in_lead);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (a_ready) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      fa_r    <= in_flags;
      acca_r  <= in_acc;
      topa_r  <= topa_nxt;
      norma_r <= in_mant << lsh;
    end
  end

  // Pick the shift that leaves 53 bits for normals, fewer for subnormals
  assign over_nxt  = topa_r > TOP_MAX;
  assign under_nxt = topa_r < TOP_MIN;
  assign norm_nxt  = topa_r >= TOP_NORM_MIN;
  assign sub_amt   = SUB_BASE - topa_r;
  assign rsh       = norm_nxt ? NORM_SHIFT : sub_amt[6:0];
  assign shifted   = norma_r >> rsh;
  assign gidx      = 6'(rsh - 7'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (b_ready) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && va_r) begin
      fb_r     <= fa_r;
      accb_r   <= acca_r;
      overb_r  <= over_nxt;
      underb_r <= under_nxt;
      normb_r  <= norm_nxt;
      fieldb_r <= norm_nxt ? EXP_W'(topa_r + FIELD_BIAS) : '0;
      sigb_r   <= shifted[SIG_W-1:0];
      guardb_r <= norma_r[gidx];
      lowerb_r <= (norma_r << (7'd65 - rsh)) != '0;
    end
  end

  // Round half to even; the hidden bit and any carry step the exponent field
  assign inc = guardb_r && (lowerb_r || fb_r.sticky || sigb_r[0]);
  assign mag = {fieldb_r, {FRC_W{1'b0}}} + 63'(sigb_r) + 63'(inc);

  always_comb begin
    value_nxt = {fb_r.negative, 63'd0};
    rng_nxt   = 1'b0;
    len_nxt   = fb_r.hex_form ? accb_r : '0;
    if (!fb_r.hex_form) begin
      value_nxt = '0;
    end else if (fb_r.nonzero) begin
      if (overb_r) begin
        value_nxt = {fb_r.negative, EXP_ALL, {FRC_W{1'b0}}};
        rng_nxt   = 1'b1;
      end else if (underb_r) begin
        rng_nxt = 1'b1;
      end else if (normb_r) begin
        value_nxt = {fb_r.negative, mag};
        rng_nxt   = (mag[62:FRC_W] == EXP_ALL);
      end else begin
        value_nxt = {fb_r.negative, mag};
        rng_nxt   = fb_r.sticky || guardb_r || lowerb_r || (mag == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (c_ready) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && vb_r) begin
      value_r <= value_nxt;
      len_r   <= len_nxt;
      rng_r   <= rng_nxt;
      hex_r   <= fb_r.hex_form;
    end
  end

  assign out_valid           = vc_r;
  assign out_value_bits      = value_r;
  assign out_consumed_length = len_r;
  assign out_range_error     = rng_r;
  assign out_hex_form        = hex_r;

endmodule

// ===== hdl/hex_float_string_to_double.sv =====
// ----------------------------------------------------------------------------
// hex_float_string_to_double
// Hex floating text, one byte per transfer, to an IEEE binary64 result.
// ----------------------------------------------------------------------------
//   channel  ports                                    direction
//   in       in_valid/in_ready, in_text_byte,         into block
//            in_starts_text
//   out      out_valid/out_ready, out_value_bits,     out of block
//            out_consumed_length, out_range_error, out_hex_form
//
// One text byte is taken every cycle; the parser updates its state per byte.
// The ending byte pushes a record into a four-entry queue; the rounder then
// runs it through align, shift and round stages and offers the result.
// Input stalls only while the queue is full; the rounder stalls on out_ready.
// Synchronous active-low reset; no clearing pass, input ready after reset.
// ----------------------------------------------------------------------------
module hex_float_string_to_double #(
  parameter int MAX_TEXT_LENGTH = 4096,
  parameter int KEPT_HEX_DIGITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_text_byte,
  input  logic                                   in_starts_text,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [63:0]                            out_value_bits,
  output logic [$clog2(MAX_TEXT_LENGTH+1)-1:0]   out_consumed_length,
  output logic                                   out_range_error,
  output logic                                   out_hex_form
);
  import hfsd_pkg::*;

  localparam int LEN_W = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int KC_W  = $clog2(KEPT_HEX_DIGITS + 1);
  localparam int REC_W = $bits(fin_flags_t) + MANT_W + LEAD_W + KC_W + 3 * LEN_W + EXP_MAG_W;

  logic                 f_push;
  logic                 f_room;
  fin_flags_t           f_flags;
  logic [MANT_W-1:0]    f_mant;
  logic [LEAD_W-1:0]    f_lead;
  logic [KC_W-1:0]      f_kept;
  logic [LEN_W-1:0]     f_radix;
  logic [LEN_W-1:0]     f_fnz;
  logic [LEN_W-1:0]     f_acc;
  logic [EXP_MAG_W-1:0] f_exp_mag;

  logic [REC_W-1:0]     q_wr_data;
  logic [REC_W-1:0]     q_rd_data;
  logic                 q_rd_valid;
  logic                 q_rd_ready;

  fin_flags_t           b_flags;
  logic [MANT_W-1:0]    b_mant;
  logic [LEAD_W-1:0]    b_lead;
  logic [KC_W-1:0]      b_kept;
  logic [LEN_W-1:0]     b_radix;
  logic [LEN_W-1:0]     b_fnz;
  logic [LEN_W-1:0]     b_acc;
  logic [EXP_MAG_W-1:0] b_exp_mag;

  // Parser
  hfsd_front #(
    .MAX_LEN (MAX_TEXT_LENGTH),
    .KEPT    (KEPT_HEX_DIGITS),
    .LEN_W   (LEN_W),
    .KC_W    (KC_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_starts_text (in_starts_text),
    .fin_push       (f_push),
    .fin_room       (f_room),
    .fin_flags      (f_flags),
    .fin_mant       (f_mant),
    .fin_lead       (f_lead),
    .fin_kept       (f_kept),
    .fin_radix      (f_radix),
    .fin_fnz        (f_fnz),
    .fin_acc        (f_acc),
    .fin_exp_mag    (f_exp_mag)
  );

  // Pack and unpack the finished record around the queue
  assign q_wr_data = {f_flags, f_mant, f_lead, f_kept, f_radix, f_fnz, f_acc, f_exp_mag};
  assign {b_flags, b_mant, b_lead, b_kept, b_radix, b_fnz, b_acc, b_exp_mag} = q_rd_data;

  hfsd_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_push),
    .wr_ready (f_room),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  // Rounder
  hfsd_back #(
    .LEN_W (LEN_W),
    .KC_W  (KC_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (q_rd_valid),
    .in_ready            (q_rd_ready),
    .in_flags            (b_flags),
    .in_mant             (b_mant),
    .in_lead             (b_lead),
    .in_kept             (b_kept),
    .in_radix            (b_radix),
    .in_fnz              (b_fnz),
    .in_acc              (b_acc),
    .in_exp_mag          (b_exp_mag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_value_bits      (out_value_bits),
    .out_consumed_length (out_consumed_length),
    .out_range_error     (out_range_error),
    .out_hex_form        (out_hex_form)
  );

endmodule

// ===== tb/sv/hex_float_string_to_double_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_float_string_to_double_checker
// Watches both channels of the hex text converter, parses every accepted
// byte in its own copy of the parser, rounds each finished text to binary64
// and compares the results in order of arrival.
// ----------------------------------------------------------------------------
module hex_float_string_to_double_checker #(
  parameter int MAX_TEXT_LENGTH = 4096,
  parameter int KEPT_HEX_DIGITS = 16,
  parameter int LEN_W           = $clog2(MAX_TEXT_LENGTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_text_byte,
  input  logic             in_starts_text,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [63:0]      out_value_bits,
  input  logic [LEN_W-1:0] out_consumed_length,
  input  logic             out_range_error,
  input  logic             out_hex_form,
  output int               mismatch_count,
  output int               outstanding
);

  import hfsd_pkg::*;

  localparam logic [63:0] EXP_FIELD_ALL = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK     = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] SIGN_BIT      = 64'h8000_0000_0000_0000;
  localparam int          EXP_BIAS      = 1023;
  localparam int          MIN_NORM_EXP  = -1022;
  localparam int          MIN_SUB_EXP   = -1074;
  localparam int          SIG_BITS      = 53;

  typedef struct packed {
    logic [63:0]      value;
    logic [LEN_W-1:0] length;
    logic             range_err;
    logic             hex;
  } conv_t;

  // Parser state of the text in progress
  phase_t      txt_phase;
  logic        txt_negative;
  logic [63:0] sig_bits;
  int          sig_kept;
  int          mant_digits;
  int          point_at;
  int          first_nonzero_at;
  logic        seen_digit;
  logic        seen_point;
  logic        seen_nonzero;
  logic        sticky_seen;
  int          exp_value;
  int          byte_count;
  int          accepted_len;

  conv_t pending_values[$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at %0t ns: got %h, want %h", what, $time, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic clear_text();
    txt_phase        = PH_LEAD;
    txt_negative     = 1'b0;
    sig_bits         = '0;
    sig_kept         = 0;
    mant_digits      = 0;
    point_at         = 0;
    first_nonzero_at = 0;
    seen_digit       = 1'b0;
    seen_point       = 1'b0;
    seen_nonzero     = 1'b0;
    sticky_seen      = 1'b0;
    exp_value        = 0;
    byte_count       = 0;
    accepted_len     = 0;
  endtask

  function automatic int hex_digit_value(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | 8'h20;
    if (ch >= "0" && ch <= "9") return int'(ch) - 48;
    if (lc >= "a" && lc <= "f") return int'(lc) - 87;
    return -1;
  endfunction

  // Accumulate one decimal exponent digit, saturating the magnitude
  task automatic add_exp_digit(input int dig, input bit minus);
    longint mag;
    longint lim;
    lim = longint'(EXP_LIMIT);
    mag = (exp_value < 0) ? -longint'(exp_value) : longint'(exp_value);
    if (mag > (lim - dig) / 10) mag = lim;
    else mag = mag * 10 + dig;
    exp_value = minus ? int'(-mag) : int'(mag);
  endtask

  // Round the finished text into a binary64 pattern
  function automatic conv_t round_to_binary64();
    conv_t       res;
    logic [63:0] bits, r, rem, half, one, ebits;
    longint      radix, scale, e2, top, d;
    int          nb, disc;
    bit          sticky, inexact, rng;
    res   = '0;
    one   = 64'd1;
    bits  = txt_negative ? SIGN_BIT : 64'd0;
    rng   = 1'b0;
    if (txt_phase == PH_LEAD || txt_phase == PH_SIGNED || txt_phase == PH_ZERO ||
        txt_phase == PH_OTHER) begin
      return res;
    end
    if (seen_nonzero && sig_bits != 0) begin
      radix  = seen_point ? longint'(point_at) : longint'(mant_digits);
      scale  = radix - first_nonzero_at - sig_kept;
      e2     = longint'(exp_value) + 4 * scale;
      nb     = 0;
      for (int i = 0; i < 64; i++) begin
        if (sig_bits[i]) nb = i + 1;
      end
      top    = e2 + nb - 1;
      sticky = sticky_seen;
      if (top > EXP_BIAS) begin
        bits = bits | EXP_FIELD_ALL;
        rng  = 1'b1;
      end else if (top < MIN_SUB_EXP - 1) begin
        rng = 1'b1;
      end else if (top >= MIN_NORM_EXP) begin
        // normal range: keep 53 bits, round half to even
        disc = (nb > SIG_BITS) ? nb - SIG_BITS : 0;
        r = (disc != 0) ? (sig_bits >> disc) : (sig_bits << (SIG_BITS - nb));
        if (disc != 0) begin
          rem  = sig_bits & ((one << disc) - 1);
          half = one << (disc - 1);
          if (rem > half || (rem == half && (sticky || r[0]))) r = r + 1;
        end
        if (r == (one << SIG_BITS)) begin
          r   = r >> 1;
          top = top + 1;
        end
        if (top > EXP_BIAS) begin
          bits = bits | EXP_FIELD_ALL;
          rng  = 1'b1;
        end else begin
          ebits = top + EXP_BIAS;
          bits  = bits | (ebits << 52) | (r & FRAC_MASK);
        end
      end else begin
        // subnormal range: align to the smallest step
        d       = MIN_SUB_EXP - e2;
        r       = '0;
        inexact = sticky;
        if (d <= 0) begin
          if (-d < 64) r = sig_bits << (-d);
        end else if (d < 64) begin
          rem  = sig_bits & ((one << d) - 1);
          half = one << (d - 1);
          r    = sig_bits >> d;
          if (rem != 0) inexact = 1'b1;
          if (rem > half || (rem == half && (sticky || r[0]))) r = r + 1;
        end else if (d == 64) begin
          inexact = 1'b1;
          if (sig_bits > SIGN_BIT || (sig_bits == SIGN_BIT && sticky)) r = 64'd1;
        end else begin
          inexact = 1'b1;
        end
        if (inexact || r == 0) rng = 1'b1;
        bits = bits | r;
      end
    end
    res.value     = bits;
    res.length    = LEN_W'(accepted_len);
    res.range_err = rng;
    res.hex       = 1'b1;
    return res;
  endfunction

  // Advance the parser by one byte; flag a result when the text ends
  task automatic parse_text_byte(input logic [7:0] ch_in, input logic starts,
                                 output bit emit, output conv_t res);
    logic [7:0] ch;
    int         pos;
    int         dig;
    bit         minus;
    emit = 1'b0;
    res  = '0;
    if (starts) clear_text();
    if (txt_phase != PH_DONE) begin
      ch  = ch_in;
      pos = byte_count;
      if (pos >= MAX_TEXT_LENGTH) ch = 8'd0;
      else byte_count = pos + 1;
      if (ch == 8'd0) begin
        res       = round_to_binary64();
        txt_phase = PH_DONE;
        emit      = 1'b1;
      end else begin
        dig = hex_digit_value(ch);
        case (txt_phase)
          PH_LEAD, PH_SIGNED: begin
            if (txt_phase == PH_LEAD && (ch == " " || (ch >= 8'd9 && ch <= 8'd13))) begin
              // skip white space
            end else if (txt_phase == PH_LEAD && (ch == "+" || ch == "-")) begin
              txt_negative = (ch == "-");
              txt_phase    = PH_SIGNED;
            end else if (ch == "0") begin
              accepted_len = pos + 1;
              txt_phase    = PH_ZERO;
            end else begin
              txt_phase = PH_OTHER;
            end
          end
          PH_ZERO: begin
            if ((ch | 8'h20) == "x") txt_phase = PH_MANT;
            else txt_phase = PH_OTHER;
          end
          PH_MANT: begin
            if (dig >= 0) begin
              seen_digit = 1'b1;
              if (!seen_nonzero && dig != 0) begin
                seen_nonzero     = 1'b1;
                first_nonzero_at = mant_digits;
              end
              if (seen_nonzero) begin
                if (sig_kept < KEPT_HEX_DIGITS) begin
                  sig_bits = {sig_bits[59:0], dig[3:0]};
                  sig_kept = sig_kept + 1;
                end else if (dig != 0) begin
                  sticky_seen = 1'b1;
                end
              end
              if (mant_digits < MAX_TEXT_LENGTH) mant_digits = mant_digits + 1;
              accepted_len = pos + 1;
            end else if (ch == "." && !seen_point) begin
              seen_point = 1'b1;
              point_at   = mant_digits;
              if (seen_digit) accepted_len = pos + 1;
            end else if ((ch | 8'h20) == "p" && seen_digit) begin
              txt_phase = PH_EXP;
            end else begin
              txt_phase = PH_TRAIL;
            end
          end
          PH_EXP, PH_EXP_PLUS, PH_EXP_MINUS, PH_EXP_DIG_PLUS, PH_EXP_DIG_MINUS: begin
            if (txt_phase == PH_EXP && ch == "+") begin
              txt_phase = PH_EXP_PLUS;
            end else if (txt_phase == PH_EXP && ch == "-") begin
              txt_phase = PH_EXP_MINUS;
            end else if (ch >= "0" && ch <= "9") begin
              minus = (txt_phase == PH_EXP_MINUS || txt_phase == PH_EXP_DIG_MINUS);
              add_exp_digit(int'(ch) - 48, minus);
              accepted_len = pos + 1;
              if (minus) txt_phase = PH_EXP_DIG_MINUS;
              else txt_phase = PH_EXP_DIG_PLUS;
            end else begin
              txt_phase = PH_TRAIL;
            end
          end
          default: begin
          end
        endcase
      end
    end
  endtask

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin : watch
    conv_t want;
    bit    emit;
    if (!rst_n) begin
      clear_text();
      pending_values.delete();
    end else begin
      if (in_valid && in_ready) begin
        parse_text_byte(in_text_byte, in_starts_text, emit, want);
        if (emit) pending_values.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_values.size() == 0) begin
          report_mismatch("result with nothing expected", out_value_bits, 64'd0);
        end else begin
          want = pending_values.pop_front();
          if (out_value_bits !== want.value)
            report_mismatch("value_bits", out_value_bits, want.value);
          if (out_consumed_length !== want.length)
            report_mismatch("consumed_length", 64'(out_consumed_length), 64'(want.length));
          if (out_range_error !== want.range_err)
            report_mismatch("range_error", 64'(out_range_error), 64'(want.range_err));
          if (out_hex_form !== want.hex)
            report_mismatch("hex_form", 64'(out_hex_form), 64'(want.hex));
        end
      end
    end
    outstanding <= pending_values.size();
  end

endmodule

// ===== tb/sv/hex_float_string_to_double_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_float_string_to_double_tb
// Feeds directed and random hex floating texts, byte by byte, through the
// converter under several idling patterns and a long receiver hold-off; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hex_float_string_to_double_tb;

  localparam int MAX_TEXT_LENGTH = 4096;
  localparam int KEPT_HEX_DIGITS = 16;
  localparam int LEN_W           = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int RANDOM_BYTES    = 900;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RUN_LIMIT_NS    = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_text_byte;
  logic             in_starts_text;
  logic             out_valid;
  logic             out_ready;
  logic [63:0]      out_value_bits;
  logic [LEN_W-1:0] out_consumed_length;
  logic             out_range_error;
  logic             out_hex_form;

  int         mismatch_count;
  int         outstanding;
  int         in_idle_pct;
  int         out_stall_pct;
  bit         hold_off_req;
  logic [7:0] text_q[$];

  hex_float_string_to_double #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH),
    .KEPT_HEX_DIGITS(KEPT_HEX_DIGITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_starts_text     (in_starts_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_value_bits     (out_value_bits),
    .out_consumed_length(out_consumed_length),
    .out_range_error    (out_range_error),
    .out_hex_form       (out_hex_form)
  );

  hex_float_string_to_double_checker #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH),
    .KEPT_HEX_DIGITS(KEPT_HEX_DIGITS)
  ) i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_starts_text     (in_starts_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_value_bits     (out_value_bits),
    .out_consumed_length(out_consumed_length),
    .out_range_error    (out_range_error),
    .out_hex_form       (out_hex_form),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  initial clk = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("hex_float_string_to_double test failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
          held++;
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Offer one byte from a falling edge; return at the falling edge after transfer
  task automatic send_byte(input logic [7:0] b, input logic starts);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_starts_text <= starts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input bit first_starts);
    foreach (text_q[i]) send_byte(text_q[i], (i == 0) ? first_starts : 1'b0);
    text_q.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s.getc(i));
  endtask

  task automatic send_directed(input string s);
    push_str(s);
    text_q.push_back(8'd0);
    send_text(1'b1);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(48 + v);
    if ($urandom_range(1)) return 8'(87 + v);
    return 8'(55 + v);
  endfunction

  // Hex digits; the biased set makes ties and carries more likely
  task automatic add_hex_digits(input int n, input bit biased);
    int v;
    repeat (n) begin
      if (biased) begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 8;
          2: v = 15;
          default: v = 1;
        endcase
      end else begin
        v = $urandom_range(15);
      end
      text_q.push_back(hex_char(v));
    end
  endtask

  function automatic int digit_run();
    if ($urandom_range(4) == 0) return $urandom_range(22, 0);
    return $urandom_range(6, 0);
  endfunction

  // Mostly well-formed hex text with random content, always terminated
  task automatic gen_hex_text();
    int sel;
    bit biased;
    biased = ($urandom_range(3) == 0);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) begin
        sel = $urandom_range(5);
        text_q.push_back((sel == 0) ? 8'd32 : 8'(8 + sel));
      end
    end
    case ($urandom_range(2))
      1: push_str("+");
      2: push_str("-");
      default: begin
      end
    endcase
    push_str($urandom_range(1) ? "0x" : "0X");
    if ($urandom_range(3) == 0) repeat ($urandom_range(20, 1)) push_str("0");
    add_hex_digits(digit_run(), biased);
    if ($urandom_range(1)) begin
      push_str(".");
      add_hex_digits(digit_run(), biased);
    end
    sel = $urandom_range(19);
    if (sel < 14) begin
      push_str($urandom_range(1) ? "p" : "P");
      case ($urandom_range(2))
        1: push_str("+");
        2: push_str("-");
        default: begin
        end
      endcase
      if (sel == 0) begin
        // long digit runs, mostly past the saturation point
        repeat ($urandom_range(14, 8)) text_q.push_back(8'(48 + $urandom_range(9)));
      end else if (sel < 6) begin
        push_str($sformatf("%0d", $urandom_range(40)));
      end else begin
        push_str($sformatf("%0d", $urandom_range(1160, 960)));
      end
    end else if (sel == 14) begin
      // exponent marker with nothing after it
      push_str("p");
      if ($urandom_range(1)) push_str($urandom_range(1) ? "+" : "-");
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255, 1)));
    end
    text_q.push_back(8'd0);
  endtask

  // Malformed or foreign texts, and texts cut short
  task automatic gen_noise_text();
    string alphabet;
    alphabet = "0xXpP.+-19aF8 g";
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255, 1)));
        text_q.push_back(8'd0);
      end
      1: begin
        if ($urandom_range(1)) push_str("0x");
        repeat ($urandom_range(12, 1))
          text_q.push_back(alphabet.getc($urandom_range(alphabet.len() - 1)));
        text_q.push_back(8'd0);
      end
      2: begin
        case ($urandom_range(3))
          0: push_str("12.5e3");
          1: push_str("-INF");
          2: push_str("nan");
          default: push_str("+-0x1");
        endcase
        text_q.push_back(8'd0);
      end
      default: begin
        // drop the tail so the next text restarts mid-parse
        gen_hex_text();
        while (text_q.size() > 1 && $urandom_range(2) != 0) void'(text_q.pop_back());
        if (text_q[text_q.size() - 1] == 8'd0) void'(text_q.pop_back());
        if (text_q.size() == 0) push_str("0x1");
      end
    endcase
  endtask

  initial begin : stimulus
    int sent;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = 8'd0;
    in_starts_text = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    hold_off_req   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First text after reset goes without a start marker
    push_str("0x1p0");
    text_q.push_back(8'd0);
    send_text(1'b0);
    // Bytes after a finished text are ignored until the next start
    push_str("0x2p0");
    text_q.push_back(8'd0);
    send_text(1'b0);

    // Every white space kind, then a sign
    text_q = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    push_str("-0X1.8P+1");
    text_q.push_back(8'd0);
    send_text(1'b1);

    send_directed("+0xA.bCp-3");
    send_directed("0x");
    send_directed("-0x.p1");
    send_directed("0xp3");
    send_directed("-0x.8p1");
    send_directed("0x000.000p9999");
    send_directed("0x1p");
    send_directed("0x1p-");
    send_directed("0x1.fffffffffffff8p1023");
    send_directed("0x1.fffffffffffffp1023");
    send_directed("0x1p1024");
    send_directed("0x1p-1022");
    send_directed("0x1.fffffffffffffp-1023");
    send_directed("0x1p-1074");
    send_directed("0x1p-1075");
    send_directed("0x1.00000000000000001p-1075");
    send_directed("0x3p-1076");
    send_directed("0x8000000000000000p-1138");
    send_directed("0x80000000000000001p-1142");
    send_directed("0x123456789abcdef123p0");
    send_directed("0x1p99999999999");
    send_directed("-0x1p-99999999999");
    send_directed("0x1p4 junk");
    send_directed("1.5");
    send_directed("inf");

    // Unfinished text dropped by a new start
    push_str("0x1.8");
    send_text(1'b1);
    text_q.push_back(8'hff);
    push_str("0x1");
    text_q.push_back(8'd0);
    send_text(1'b1);

    // Long digit run: only the leading digits are kept, the rest feed sticky
    push_str("0x1");
    add_hex_digits(200, 1'b0);
    text_q.push_back(8'd0);
    send_text(1'b1);

    // Long runs of zeros push the point and digit counters up
    push_str("0x");
    repeat (300) push_str("0");
    push_str(".");
    repeat (100) push_str("0");
    push_str("1p400");
    text_q.push_back(8'd0);
    send_text(1'b1);

    // Random texts under each idling pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          hold_off_req  = 1'b1;
        end
        1: begin
          in_idle_pct   = 82;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 82;
        end
        default: begin
          in_idle_pct   = 19;
          out_stall_pct = 19;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_BYTES / 4) begin
        if ($urandom_range(4) == 0) gen_noise_text();
        else gen_hex_text();
        sent += text_q.size();
        send_text($urandom_range(29) != 0);
      end
    end

    // Drain and give the verdict
    in_valid      <= 1'b0;
    out_stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("hex_float_string_to_double test passed");
    end else begin
      $display("hex_float_string_to_double test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hfsd_pkg.sv
hdl/hfsd_front.sv
hdl/hfsd_queue.sv
hdl/hfsd_back.sv
hdl/hex_float_string_to_double.sv
tb/sv/hex_float_string_to_double_checker.sv
tb/sv/hex_float_string_to_double_tb.sv
